// ----- hw/rtl/bvs_pkg.sv -----
// ----------------------------------------------------------------------------
// Battery voltage sense package
// Field widths, scaling constants, register indexes and the shared
// divide-by-1000 helper used by the sense chain.
// ----------------------------------------------------------------------------
package bvs_pkg;

    // Converter resolution: the pin voltage is counts * ref / 2^ADC_BITS.
    localparam int ADC_BITS = 10;

    // Field widths.
    localparam int COUNTS_W = 10;
    localparam int REF_W    = 13;
    localparam int DUTY_W   = 7;
    localparam int PIN_W    = 13;
    localparam int MV_W     = 16;
    localparam int RATIO_W  = 15;
    localparam int RES_W    = 10;
    localparam int QUIES_W  = 10;

    // Configuration port.
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 16;

    // Saturation limits and thresholds.
    localparam logic [PIN_W-1:0]  PIN_MAX        = 13'd8191;
    localparam logic [MV_W-1:0]   MV_MAX         = 16'd65535;
    localparam logic [MV_W-1:0]   LOW_READING_MV = 16'd1000;
    localparam logic [DUTY_W-1:0] DUTY_MAX       = 7'd100;

    // Register reset values.
    localparam logic [RATIO_W-1:0] RATIO_RESET    = 15'd5700;
    localparam logic [RES_W-1:0]   RES_RESET      = 10'd0;
    localparam logic [MV_W-1:0]    POWER_RESET    = 16'd0;
    localparam logic [QUIES_W-1:0] QUIES_RESET    = 10'd80;
    localparam logic [MV_W-1:0]    MAX_CORR_RESET = 16'd500;

    // Product widths.
    localparam int PROD_PIN_W  = COUNTS_W + REF_W;  // counts * ref
    localparam int PROD_LOAD_W = MV_W + DUTY_W;     // full power * duty
    localparam int PROD_PACK_W = PIN_W + RATIO_W;   // pin * ratio
    localparam int CUR_W       = MV_W + 1;          // quiescent + load current
    localparam int PROD_DROP_W = CUR_W + RES_W;     // current * resistance

    // Divide by 100 as a shift by 2 and a reciprocal multiply by 1/25.
    // The rounded-up reciprocal is exact for all dividends below 2^21.
    localparam int                Y25_W     = PROD_LOAD_W - 2;
    localparam int                RECIP25_W = 22;
    localparam logic [RECIP25_W-1:0] RECIP_25 = 22'd2684355;
    localparam int                SHIFT_25  = 26;

    // Divide by 1000 as a shift by 3 and a reciprocal multiply by 1/125.
    // The rounded-up reciprocal is exact for all dividends below 2^25.
    localparam int                 DIV1000_IN_W = 28;
    localparam int                 Y125_W       = DIV1000_IN_W - 3;
    localparam int                 RECIP125_W   = 26;
    localparam logic [RECIP125_W-1:0] RECIP_125 = 26'd34359739;
    localparam int                 SHIFT_125    = 32;
    localparam int                 QUO1000_W    = Y125_W + RECIP125_W - SHIFT_125;

    // Scale of the load current numerator (mW * 1000 / mV = mA).
    localparam logic [9:0] MILLI_SCALE = 10'd1000;
    localparam int         NUM_W       = 26;

    // The load current quotient fits in 16 bits whenever the pack voltage is
    // at least 1000 mV, so the divider chain needs one cell per quotient bit.
    localparam int DIV_STEPS = MV_W;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_DIVIDER_RATIO  = 3'd0,
        REG_HARNESS_RES    = 3'd1,
        REG_LOAD_POWER     = 3'd2,
        REG_QUIESCENT      = 3'd3,
        REG_MAX_CORRECTION = 3'd4
    } reg_index_t;

    // Configuration values as seen by the datapath.
    typedef struct packed {
        logic [RATIO_W-1:0] divider_ratio;
        logic [RES_W-1:0]   harness_res;
        logic [MV_W-1:0]    load_power;
        logic [QUIES_W-1:0] quiescent;
        logic [MV_W-1:0]    max_correction;
    } cfg_t;

    // Item that travels through the divider chain.
    typedef struct packed {
        logic [PIN_W-1:0]     pin_mv;
        logic [MV_W-1:0]      pack_mv;
        logic                 bypass;
        logic [MV_W-1:0]      rem;
        logic [DIV_STEPS-1:0] num;
        logic [MV_W-1:0]      quo;
    } div_item_t;

    // Floor of x / 1000 for x below 2^28.
    function automatic logic [QUO1000_W-1:0] div1000(input logic [DIV1000_IN_W-1:0] x);
        logic [Y125_W-1:0]            y;
        logic [Y125_W+RECIP125_W-1:0] p;
        y = x[DIV1000_IN_W-1:3];
        p = (Y125_W + RECIP125_W)'(y) * (Y125_W + RECIP125_W)'(RECIP_125);
        return p[Y125_W+RECIP125_W-1:SHIFT_125];
    endfunction

endpackage

// ----- hw/rtl/bvs_in_if.sv -----
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one converter sample per transfer.
// ----------------------------------------------------------------------------
interface bvs_in_if import bvs_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [COUNTS_W-1:0] adc_counts;
    logic [REF_W-1:0]    ref_supply_mv;
    logic [DUTY_W-1:0]   duty_percent;

    modport source (
        output valid,
        output adc_counts,
        output ref_supply_mv,
        output duty_percent,
        input  ready
    );

    modport sink (
        input  valid,
        input  adc_counts,
        input  ref_supply_mv,
        input  duty_percent,
        output ready
    );

endinterface

// ----- hw/rtl/bvs_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the three voltages of one sample.
// ----------------------------------------------------------------------------
interface bvs_out_if import bvs_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [PIN_W-1:0] sense_pin_mv;
    logic [MV_W-1:0]  pack_voltage_mv;
    logic [MV_W-1:0]  corrected_pack_mv;

    modport source (
        output valid,
        output sense_pin_mv,
        output pack_voltage_mv,
        output corrected_pack_mv,
        input  ready
    );

    modport sink (
        input  valid,
        input  sense_pin_mv,
        input  pack_voltage_mv,
        input  corrected_pack_mv,
        output ready
    );

endinterface

// ----- hw/rtl/bvs_front.sv -----
// ----------------------------------------------------------------------------
// Sense chain front end
// Five pipeline stages: pin voltage, load power, pack voltage and the
// numerator of the load current division, then the divider chain seed.
// ----------------------------------------------------------------------------
module bvs_front import bvs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    bvs_in_if.sink    sample,
    output div_item_t item,
    output logic      item_valid,
    input  logic      item_ready
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] valid_in;
    logic [STAGES-1:0] load;

    // Stage 1: raw products.
    logic [DUTY_W-1:0]      duty_clamped;
    logic [PROD_PIN_W-1:0]  s1_prod_pin_reg;
    logic [PROD_LOAD_W-1:0] s1_prod_load_reg;

    // Stage 2: pin voltage and load power.
    logic [PROD_PIN_W-1:0]          pin_shift;
    logic [PIN_W-1:0]               pin_next;
    logic [Y25_W-1:0]               load_y;
    logic [Y25_W+RECIP25_W-1:0]     load_prod;
    logic [PIN_W-1:0]               s2_pin_reg;
    logic [MV_W-1:0]                s2_load_mw_reg;

    // Stage 3: pack product and current numerator.
    logic [PIN_W-1:0]       s3_pin_reg;
    logic [PROD_PACK_W-1:0] s3_prod_pack_reg;
    logic [NUM_W-1:0]       s3_num_reg;

    // Stage 4: pack quotient.
    logic [PIN_W-1:0]     s4_pin_reg;
    logic [QUO1000_W-1:0] s4_pack_q_reg;
    logic [NUM_W-1:0]     s4_num_reg;

    // Stage 5: divider seed.
    logic [MV_W-1:0] pack_sat;
    div_item_t       item_reg;
    div_item_t       item_next;

    // A stage takes new data when it is empty or its successor moves on.
    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || item_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    assign valid_in   = {valid_reg[STAGES-2:0], sample.valid};
    assign valid_next = (load & valid_in) | (~load & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1 multiplies the sample fields.
    assign duty_clamped = (sample.duty_percent > DUTY_MAX) ? DUTY_MAX : sample.duty_percent;

    always_ff @(posedge clk)
    begin
        if (load[0] && valid_in[0])
        begin
            s1_prod_pin_reg  <= PROD_PIN_W'(sample.adc_counts) * PROD_PIN_W'(sample.ref_supply_mv);
            s1_prod_load_reg <= PROD_LOAD_W'(cfg.load_power) * PROD_LOAD_W'(duty_clamped);
        end
    end

    // Stage 2 scales the pin voltage and divides the load power by 100.
    assign pin_shift = s1_prod_pin_reg >> ADC_BITS;
    assign pin_next  = (pin_shift > PROD_PIN_W'(PIN_MAX)) ? PIN_MAX : pin_shift[PIN_W-1:0];
    assign load_y    = s1_prod_load_reg[PROD_LOAD_W-1:2];
    assign load_prod = (Y25_W + RECIP25_W)'(load_y) * (Y25_W + RECIP25_W)'(RECIP_25);

    always_ff @(posedge clk)
    begin
        if (load[1] && valid_in[1])
        begin
            s2_pin_reg     <= pin_next;
            s2_load_mw_reg <= load_prod[SHIFT_25 +: MV_W];
        end
    end

    // Stage 3 applies the divider ratio and scales the load power to mW * 1000.
    always_ff @(posedge clk)
    begin
        if (load[2] && valid_in[2])
        begin
            s3_pin_reg       <= s2_pin_reg;
            s3_prod_pack_reg <= PROD_PACK_W'(s2_pin_reg) * PROD_PACK_W'(cfg.divider_ratio);
            s3_num_reg       <= NUM_W'(s2_load_mw_reg) * NUM_W'(MILLI_SCALE);
        end
    end

    // Stage 4 divides the pack product by 1000.
    always_ff @(posedge clk)
    begin
        if (load[3] && valid_in[3])
        begin
            s4_pin_reg    <= s3_pin_reg;
            s4_pack_q_reg <= div1000(DIV1000_IN_W'(s3_prod_pack_reg));
            s4_num_reg    <= s3_num_reg;
        end
    end

    // Stage 5 saturates the pack voltage and seeds the divider. The top ten
    // numerator bits stay below 1000, so they form the first partial remainder.
    assign pack_sat = (s4_pack_q_reg > QUO1000_W'(MV_MAX)) ? MV_MAX
                                                          : s4_pack_q_reg[MV_W-1:0];

    always_comb
    begin
        item_next.pin_mv  = s4_pin_reg;
        item_next.pack_mv = pack_sat;
        item_next.bypass  = (cfg.harness_res == '0) || (pack_sat < LOW_READING_MV);
        item_next.rem     = MV_W'(s4_num_reg[NUM_W-1:DIV_STEPS]);
        item_next.num     = s4_num_reg[DIV_STEPS-1:0];
        item_next.quo     = '0;
    end

    always_ff @(posedge clk)
    begin
        if (load[4] && valid_in[4])
        begin
            item_reg <= item_next;
        end
    end

    assign item         = item_reg;
    assign item_valid   = valid_reg[STAGES-1];
    assign sample.ready = load[0];

endmodule

// ----- hw/rtl/bvs_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step of the load current quotient, with its own
// pipeline register and valid bit.
// ----------------------------------------------------------------------------
module bvs_cell import bvs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  div_item_t item_in,
    input  logic      valid_in,
    output logic      ready_in,
    output div_item_t item_out,
    output logic      valid_out,
    input  logic      ready_out
);

    logic          valid_reg;
    logic          load;
    logic [MV_W:0] trial;
    logic [MV_W:0] diff;
    logic          fits;
    div_item_t     item_reg;
    div_item_t     item_next;

    assign load = !valid_reg || ready_out;

    // Shift in the next numerator bit and subtract the pack voltage if it fits.
    assign trial = {item_in.rem, item_in.num[DIV_STEPS-1]};
    assign diff  = trial - {1'b0, item_in.pack_mv};
    assign fits  = trial >= {1'b0, item_in.pack_mv};

    always_comb
    begin
        item_next     = item_in;
        item_next.rem = fits ? diff[MV_W-1:0] : trial[MV_W-1:0];
        item_next.num = {item_in.num[DIV_STEPS-2:0], 1'b0};
        item_next.quo = {item_in.quo[MV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && valid_in)
        begin
            item_reg <= item_next;
        end
    end

    assign ready_in  = load;
    assign item_out  = item_reg;
    assign valid_out = valid_reg;

endmodule

// ----- hw/rtl/bvs_back.sv -----
// ----------------------------------------------------------------------------
// Sense chain back end
// Turns the load current quotient into the harness drop, clamps it and
// forms the corrected pack voltage in the output register.
// ----------------------------------------------------------------------------
module bvs_back import bvs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  div_item_t item,
    input  logic      item_valid,
    output logic      item_ready,
    bvs_out_if.source result
);

    localparam int STAGES = 3;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] valid_in;
    logic [STAGES-1:0] load;

    // Stage 1: current times resistance.
    logic [CUR_W-1:0]       current_ma;
    logic [PIN_W-1:0]       s1_pin_reg;
    logic [MV_W-1:0]        s1_pack_reg;
    logic                   s1_bypass_reg;
    logic [PROD_DROP_W-1:0] s1_prod_drop_reg;

    // Stage 2: unclamped drop.
    logic [PIN_W-1:0]     s2_pin_reg;
    logic [MV_W-1:0]      s2_pack_reg;
    logic                 s2_bypass_reg;
    logic [QUO1000_W-1:0] s2_drop_reg;

    // Stage 3: output register.
    logic [MV_W-1:0]  drop_clamped;
    logic [MV_W:0]    corr_sum;
    logic [MV_W-1:0]  corr_next;
    logic [PIN_W-1:0] out_pin_reg;
    logic [MV_W-1:0]  out_pack_reg;
    logic [MV_W-1:0]  out_corr_reg;

    // A stage takes new data when it is empty or its successor moves on.
    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || result.ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    assign valid_in   = {valid_reg[STAGES-2:0], item_valid};
    assign valid_next = (load & valid_in) | (~load & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1 adds the quiescent draw and multiplies by the harness resistance.
    assign current_ma = CUR_W'(cfg.quiescent) + CUR_W'(item.quo);

    always_ff @(posedge clk)
    begin
        if (load[0] && valid_in[0])
        begin
            s1_pin_reg       <= item.pin_mv;
            s1_pack_reg      <= item.pack_mv;
            s1_bypass_reg    <= item.bypass;
            s1_prod_drop_reg <= PROD_DROP_W'(current_ma) * PROD_DROP_W'(cfg.harness_res);
        end
    end

    // Stage 2 divides the drop product by 1000.
    always_ff @(posedge clk)
    begin
        if (load[1] && valid_in[1])
        begin
            s2_pin_reg    <= s1_pin_reg;
            s2_pack_reg   <= s1_pack_reg;
            s2_bypass_reg <= s1_bypass_reg;
            s2_drop_reg   <= div1000(DIV1000_IN_W'(s1_prod_drop_reg));
        end
    end

    // Stage 3 clamps the drop and saturates the corrected voltage. Low
    // readings and a zero resistance pass the pack voltage through.
    assign drop_clamped = (s2_drop_reg > QUO1000_W'(cfg.max_correction)) ? cfg.max_correction
                                                                         : s2_drop_reg[MV_W-1:0];
    assign corr_sum     = (MV_W + 1)'(s2_pack_reg) + (MV_W + 1)'(drop_clamped);
    assign corr_next    = s2_bypass_reg ? s2_pack_reg
                                        : (corr_sum[MV_W] ? MV_MAX : corr_sum[MV_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (load[2] && valid_in[2])
        begin
            out_pin_reg  <= s2_pin_reg;
            out_pack_reg <= s2_pack_reg;
            out_corr_reg <= corr_next;
        end
    end

    assign item_ready               = load[0];
    assign result.valid             = valid_reg[STAGES-1];
    assign result.sense_pin_mv      = out_pin_reg;
    assign result.pack_voltage_mv   = out_pack_reg;
    assign result.corrected_pack_mv = out_corr_reg;

endmodule

// ----- hw/rtl/battery_voltage_sense_chain.sv -----
// ----------------------------------------------------------------------------
// Battery voltage sense chain
// Converts a converter sample into pin, pack and harness-corrected pack
// voltages through a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle while the result side keeps up,
// and returns one result per sample, in order, after five front-end stages,
// sixteen divider cells that each resolve one bit of the load current quotient
// and three back-end stages ending in the output register. Every stage has its
// own valid bit, so bubbles close up and, while any stage is empty, a sample is
// taken even while a finished result waits. Configuration registers are
// written through cfg_write, cfg_index and cfg_data and must only change while
// no sample is in flight; writes to unused indexes are ignored.
module battery_voltage_sense_chain import bvs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    bvs_in_if.sink                sample,
    bvs_out_if.source             result,
    input  logic                  cfg_write,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [RATIO_W-1:0] divider_ratio_reg;
    logic [RES_W-1:0]   harness_res_reg;
    logic [MV_W-1:0]    load_power_reg;
    logic [QUIES_W-1:0] quiescent_reg;
    logic [MV_W-1:0]    max_correction_reg;
    cfg_t               cfg;

    div_item_t            chain_item  [DIV_STEPS+1];
    logic [DIV_STEPS:0]   chain_valid;
    logic [DIV_STEPS:0]   chain_ready;

    // Configuration registers; extra data bits are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_ratio_reg  <= RATIO_RESET;
            harness_res_reg    <= RES_RESET;
            load_power_reg     <= POWER_RESET;
            quiescent_reg      <= QUIES_RESET;
            max_correction_reg <= MAX_CORR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DIVIDER_RATIO:  divider_ratio_reg  <= cfg_data[RATIO_W-1:0];
                REG_HARNESS_RES:    harness_res_reg    <= cfg_data[RES_W-1:0];
                REG_LOAD_POWER:     load_power_reg     <= cfg_data[MV_W-1:0];
                REG_QUIESCENT:      quiescent_reg      <= cfg_data[QUIES_W-1:0];
                REG_MAX_CORRECTION: max_correction_reg <= cfg_data[MV_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        cfg.divider_ratio  = divider_ratio_reg;
        cfg.harness_res    = harness_res_reg;
        cfg.load_power     = load_power_reg;
        cfg.quiescent      = quiescent_reg;
        cfg.max_correction = max_correction_reg;
    end

    // Front end: scaling and divider seed.
    bvs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample     (sample),
        .item       (chain_item[0]),
        .item_valid (chain_valid[0]),
        .item_ready (chain_ready[0])
    );

    // Divider chain: one cell per quotient bit.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_cell
        bvs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .item_in   (chain_item[k]),
            .valid_in  (chain_valid[k]),
            .ready_in  (chain_ready[k]),
            .item_out  (chain_item[k+1]),
            .valid_out (chain_valid[k+1]),
            .ready_out (chain_ready[k+1])
        );
    end

    // Back end: harness drop and output register.
    bvs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (chain_item[DIV_STEPS]),
        .item_valid (chain_valid[DIV_STEPS]),
        .item_ready (chain_ready[DIV_STEPS]),
        .result     (result)
    );

endmodule

// ----- dv/battery_voltage_sense_chain_tb.sv -----
// ----------------------------------------------------------------------------
// Battery voltage sense chain testbench
// Drives converter samples through the valid/ready channels with random
// gaps and stalls, reprograms the scaling and harness registers between
// phases, and checks every returned voltage triple against fixed expected
// values or an in-bench model of the conversion.
// ----------------------------------------------------------------------------
module battery_voltage_sense_chain_tb;

    import bvs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Indexes that decode to no register; writes there must be dropped.
    localparam logic [IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam int NUM_REGS        = 5;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int TAIL_CYCLES     = 40;

    // Legal range of each register, in index order.
    localparam int unsigned SETTING_LO [NUM_REGS] = '{1000, 0, 0, 0, 0};
    localparam int unsigned SETTING_HI [NUM_REGS] = '{20000, 1000, 65535, 1000, 65535};

    // One voltage triple as the result channel carries it.
    typedef struct packed {
        logic [PIN_W-1:0] pin;
        logic [MV_W-1:0]  pack;
        logic [MV_W-1:0]  corr;
    } volts_t;

    // One row of the directed plan: a register write or a sample.
    typedef struct {
        bit                    is_write;
        logic [IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0] data;
        logic [COUNTS_W-1:0]   counts;
        logic [REF_W-1:0]      ref_mv;
        logic [DUTY_W-1:0]     duty;
        bit                    fixed;
        volts_t                want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bvs_in_if  sample_ch ();
    bvs_out_if result_ch ();

    battery_voltage_sense_chain dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the configuration registers.
    logic [RATIO_W-1:0] ratio_q   = RATIO_RESET;
    logic [RES_W-1:0]   res_q     = RES_RESET;
    logic [MV_W-1:0]    power_q   = POWER_RESET;
    logic [QUIES_W-1:0] quies_q   = QUIES_RESET;
    logic [MV_W-1:0]    maxcorr_q = MAX_CORR_RESET;

    volts_t      pending_volts [$];
    plan_row_t   plan [$];
    int unsigned mismatches      = 0;
    int unsigned results_checked = 0;
    int unsigned settings_count  = 0;
    bit          steady          = 1'b0;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the pipeline hangs.
    initial
    begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    // Record one mismatch with a one-line report.
    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Expected triple for one sample under the current register mirror.
    function automatic volts_t predict_volts(input logic [COUNTS_W-1:0] counts,
                                             input logic [REF_W-1:0]    ref_mv,
                                             input logic [DUTY_W-1:0]   duty);
        int unsigned pin, pack, duty_c, load, amps, drop, total;
        volts_t      v;
        pin = (32'(counts) * 32'(ref_mv)) >> ADC_BITS;
        if (pin > 32'(PIN_MAX))
            pin = 32'(PIN_MAX);
        pack = pin * 32'(ratio_q) / 32'd1000;
        if (pack > 32'(MV_MAX))
            pack = 32'(MV_MAX);
        total = pack;
        // Harness drop applies only with a nonzero resistance and a usable reading.
        if (res_q != '0 && pack >= 32'(LOW_READING_MV))
        begin
            duty_c = (duty > DUTY_MAX) ? 32'(DUTY_MAX) : 32'(duty);
            load   = 32'(power_q) * duty_c / 32'd100;
            amps   = 32'(quies_q) + load * 32'd1000 / pack;
            drop   = amps * 32'(res_q) / 32'd1000;
            if (drop > 32'(maxcorr_q))
                drop = 32'(maxcorr_q);
            total = pack + drop;
            if (total > 32'(MV_MAX))
                total = 32'(MV_MAX);
        end
        v.pin  = pin[PIN_W-1:0];
        v.pack = pack[MV_W-1:0];
        v.corr = total[MV_W-1:0];
        return v;
    endfunction

    // Wait cycles for one side of one transfer.
    function automatic int unsigned draw_wait();
        return steady ? 0 : $urandom_range(0, 15);
    endfunction

    // Candidate value for a register: an extreme, an in-range value, or raw bits.
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int unsigned lo,
                                                           input int unsigned hi);
        case ($urandom_range(0, 5))
            0:       return CFG_DATA_W'(lo);
            1:       return CFG_DATA_W'(hi);
            4:       return CFG_DATA_W'($urandom_range(0, 65535));
            default: return CFG_DATA_W'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic plan_row_t cfg_row(input logic [IDX_W-1:0]      idx,
                                          input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r          = '{default: '0};
        r.is_write = 1'b1;
        r.idx      = idx;
        r.data     = data;
        return r;
    endfunction

    function automatic plan_row_t sample_row(input int unsigned counts,
                                             input int unsigned ref_mv,
                                             input int unsigned duty);
        plan_row_t r;
        r        = '{default: '0};
        r.counts = COUNTS_W'(counts);
        r.ref_mv = REF_W'(ref_mv);
        r.duty   = DUTY_W'(duty);
        return r;
    endfunction

    function automatic plan_row_t fixed_row(input int unsigned counts,
                                            input int unsigned ref_mv,
                                            input int unsigned duty,
                                            input int unsigned pin,
                                            input int unsigned pack,
                                            input int unsigned corr);
        plan_row_t r;
        r       = sample_row(counts, ref_mv, duty);
        r.fixed = 1'b1;
        r.want  = '{pin: PIN_W'(pin), pack: MV_W'(pack), corr: MV_W'(corr)};
        return r;
    endfunction

    // Update the register mirror the way the block decodes a write.
    function automatic void apply_reg(input logic [IDX_W-1:0]      idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DIVIDER_RATIO:  ratio_q   = data[RATIO_W-1:0];
            REG_HARNESS_RES:    res_q     = data[RES_W-1:0];
            REG_LOAD_POWER:     power_q   = data[MV_W-1:0];
            REG_QUIESCENT:      quies_q   = data[QUIES_W-1:0];
            REG_MAX_CORRECTION: maxcorr_q = data[MV_W-1:0];
            default:            ;
        endcase
    endfunction

    // One register write, issued at a falling edge; returns at a falling edge.
    task automatic write_reg(input logic [IDX_W-1:0]      idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_reg(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering samples and wait until every result has come back.
    task automatic wait_until_idle();
        sample_ch.valid <= 1'b0;
        while (pending_volts.size() != 0)
            @(negedge clk);
    endtask

    // Offer one sample after a random gap and hold it until the transfer.
    task automatic send_sample(input logic [COUNTS_W-1:0] counts,
                               input logic [REF_W-1:0]    ref_mv,
                               input logic [DUTY_W-1:0]   duty,
                               input bit                  fixed,
                               input volts_t              want);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
            steady = !steady;
        gap = draw_wait();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.adc_counts    <= counts;
        sample_ch.ref_supply_mv <= ref_mv;
        sample_ch.duty_percent  <= duty;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pending_volts.push_back(fixed ? want : predict_volts(counts, ref_mv, duty));
        @(negedge clk);
    endtask

    // Result side: random stalls, and a check of every transfer.
    initial
    begin
        int unsigned stall;
        volts_t      want;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            if (pending_volts.size() == 0)
                flag_mismatch("result transfer with no sample outstanding");
            else
            begin
                want = pending_volts.pop_front();
                results_checked++;
                if (result_ch.sense_pin_mv !== want.pin)
                    flag_mismatch($sformatf("sense_pin_mv %0d, expected %0d",
                                            result_ch.sense_pin_mv, want.pin));
                if (result_ch.pack_voltage_mv !== want.pack)
                    flag_mismatch($sformatf("pack_voltage_mv %0d, expected %0d",
                                            result_ch.pack_voltage_mv, want.pack));
                if (result_ch.corrected_pack_mv !== want.corr)
                    flag_mismatch($sformatf("corrected_pack_mv %0d, expected %0d",
                                            result_ch.corrected_pack_mv, want.corr));
            end
            @(negedge clk);
        end
    end

    // Reset, directed plan, then random phases.
    initial
    begin
        logic [COUNTS_W-1:0]   counts;
        logic [REF_W-1:0]      ref_mv;
        logic [DUTY_W-1:0]     duty;
        logic [CFG_DATA_W-1:0] value;

        rst_n                   = 1'b0;
        cfg_write               = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        sample_ch.valid         = 1'b0;
        sample_ch.adc_counts    = '0;
        sample_ch.ref_supply_mv = '0;
        sample_ch.duty_percent  = '0;

        // Reset values: no harness correction, ratio 5.7.
        plan.push_back(fixed_row(0, 0, 0, 0, 0, 0));
        plan.push_back(fixed_row(1023, 8191, 100, 8183, 46643, 46643));
        plan.push_back(fixed_row(1023, 0, 0, 0, 0, 0));
        plan.push_back(fixed_row(0, 8191, 127, 0, 0, 0));
        plan.push_back(fixed_row(512, 4096, 127, 2048, 11673, 11673));
        // Highest legal ratio saturates the pack voltage.
        plan.push_back(cfg_row(REG_DIVIDER_RATIO, 16'd20000));
        plan.push_back(fixed_row(1023, 8191, 0, 8183, 65535, 65535));
        // Bit 15 of the ratio write must be dropped.
        plan.push_back(cfg_row(REG_DIVIDER_RATIO, 16'hFFFF));
        plan.push_back(fixed_row(16, 1024, 50, 16, 524, 524));
        // Unity ratio and the largest harness setting.
        plan.push_back(cfg_row(REG_DIVIDER_RATIO, 16'd1000));
        plan.push_back(cfg_row(REG_HARNESS_RES, 16'd1000));
        plan.push_back(cfg_row(REG_LOAD_POWER, 16'd65535));
        plan.push_back(cfg_row(REG_QUIESCENT, 16'd1000));
        plan.push_back(cfg_row(REG_MAX_CORRECTION, 16'd65535));
        // A reading just under the threshold passes through uncorrected.
        plan.push_back(fixed_row(1023, 1000, 100, 999, 999, 999));
        // At the threshold the drop and the sum both saturate; duty over 100 clamps.
        plan.push_back(fixed_row(1000, 1024, 100, 1000, 1000, 65535));
        plan.push_back(fixed_row(1000, 1024, 127, 1000, 1000, 65535));
        plan.push_back(fixed_row(1000, 1024, 0, 1000, 1000, 2000));
        plan.push_back(sample_row(1023, 8191, 100));
        // A zero correction limit removes the drop entirely.
        plan.push_back(cfg_row(REG_MAX_CORRECTION, 16'd0));
        plan.push_back(fixed_row(1000, 1024, 100, 1000, 1000, 1000));
        // Writes to undecoded indexes change nothing.
        plan.push_back(cfg_row(REG_MAX_CORRECTION, 16'd500));
        plan.push_back(cfg_row(REG_UNUSED_LO, 16'hFFFF));
        plan.push_back(cfg_row(REG_UNUSED_HI, 16'h0000));
        plan.push_back(sample_row(1000, 1024, 100));
        // Out-of-width bits on the harness registers are dropped.
        plan.push_back(cfg_row(REG_HARNESS_RES, 16'hFFFF));
        plan.push_back(cfg_row(REG_QUIESCENT, 16'hFFFF));
        plan.push_back(sample_row(1023, 8191, 101));
        plan.push_back(sample_row(700, 5000, 37));
        // Zero resistance disables compensation.
        plan.push_back(cfg_row(REG_HARNESS_RES, 16'd0));
        plan.push_back(fixed_row(1000, 1024, 100, 1000, 1000, 1000));
        plan.push_back(sample_row(321, 7777, 64));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed plan.
        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                wait_until_idle();
                write_reg(plan[i].idx, plan[i].data);
                settings_count++;
            end
            else
                send_sample(plan[i].counts, plan[i].ref_mv, plan[i].duty,
                            plan[i].fixed, plan[i].want);
        end

        // Random phases: reset values, all low, all high, then random mixes.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_until_idle();
            for (int r = 0; r < NUM_REGS; r++)
            begin
                case (p)
                    0:       value = '0;
                    1:       value = CFG_DATA_W'(SETTING_LO[r]);
                    2:       value = CFG_DATA_W'(SETTING_HI[r]);
                    default: value = pick_setting(SETTING_LO[r], SETTING_HI[r]);
                endcase
                if (p == 0)
                    case (reg_index_t'(r))
                        REG_DIVIDER_RATIO:  value = CFG_DATA_W'(RATIO_RESET);
                        REG_HARNESS_RES:    value = CFG_DATA_W'(RES_RESET);
                        REG_LOAD_POWER:     value = CFG_DATA_W'(POWER_RESET);
                        REG_QUIESCENT:      value = CFG_DATA_W'(QUIES_RESET);
                        REG_MAX_CORRECTION: value = CFG_DATA_W'(MAX_CORR_RESET);
                        default:            ;
                    endcase
                write_reg(IDX_W'(r), value);
            end
            write_reg(IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                      CFG_DATA_W'($urandom_range(0, 65535)));
            settings_count++;

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Mostly readings high enough to engage the harness correction.
                counts = ($urandom_range(0, 9) == 0) ? COUNTS_W'($urandom_range(0, 200))
                                                     : COUNTS_W'($urandom_range(0, 1023));
                ref_mv = ($urandom_range(0, 3) == 0) ? REF_W'($urandom_range(0, 8191))
                                                     : REF_W'($urandom_range(2500, 8191));
                duty   = ($urandom_range(0, 6) == 0) ? DUTY_W'($urandom_range(101, 127))
                                                     : DUTY_W'($urandom_range(0, 100));
                send_sample(counts, ref_mv, duty, 1'b0, '0);
            end
        end

        // Drain and give any stray result time to show up.
        wait_until_idle();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Checked %0d results across %0d register settings, %0d mismatches.",
                 results_checked, settings_count, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bvs_pkg.sv
hw/rtl/bvs_in_if.sv
hw/rtl/bvs_out_if.sv
hw/rtl/bvs_front.sv
hw/rtl/bvs_cell.sv
hw/rtl/bvs_back.sv
hw/rtl/battery_voltage_sense_chain.sv
dv/battery_voltage_sense_chain_tb.sv
